@@ rtl/tcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: request and result
// items, controller commands and datapath status.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int TCW_COLUMNS = 80;
    localparam int TCW_ROWS    = 25;

    // Request codes.
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Character codes with special meaning.
    localparam logic [7:0] CH_BLANK   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;

    localparam int TAB_STEP = 8;

    // Counter load selection.
    localparam logic [1:0] CNT_ZERO     = 2'd0;
    localparam logic [1:0] CNT_COLS     = 2'd1;
    localparam logic [1:0] CNT_LAST_ROW = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] row;
    } tcw_in_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } tcw_out_t;

    typedef struct packed {
        logic       capture;
        logic       exec;
        logic       cnt_load;
        logic [1:0] cnt_sel;
        logic       cnt_inc;
        logic       copy_rd;
        logic       blank_wr;
        logic       load_out;
    } tcw_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       need_scroll;
        logic       cnt_last;
        logic       out_free;
    } tcw_stat_t;

endpackage
`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console: takes one request, runs it, walks the screen
// store for scroll and clear, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tcw_pkg::tcw_stat_t stat,
    output tcw_pkg::tcw_cmd_t      cmd
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_BLANK  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.req_type == REQ_CLEAR) begin
                    cmd.cnt_load = 1'b1;
                    cmd.cnt_sel  = CNT_ZERO;
                    state_next   = ST_BLANK;
                end else if (stat.req_type == REQ_PUT && stat.need_scroll) begin
                    cmd.cnt_load = 1'b1;
                    cmd.cnt_sel  = CNT_COLS;
                    state_next   = ST_SCROLL;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCROLL: begin
                cmd.copy_rd = 1'b1;
                if (stat.cnt_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_DRAIN: begin
                // The last copy write retires here; then the bottom line is blanked.
                cmd.cnt_load = 1'b1;
                cmd.cnt_sel  = CNT_LAST_ROW;
                state_next   = ST_BLANK;
            end
            ST_BLANK: begin
                cmd.blank_wr = 1'b1;
                if (stat.cnt_last) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/tcw_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen store, cursor, walk counter and output register of the console.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
    parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire tcw_pkg::tcw_in_t   s_data,
    input  wire logic [7:0]         attr,
    input  wire tcw_pkg::tcw_cmd_t  cmd,
    output tcw_pkg::tcw_stat_t      stat,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tcw_pkg::tcw_out_t       m_data
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [15:0] screen_mem [CELLS];

    tcw_in_t           req_reg;
    logic [6:0]        cursor_x_reg;
    logic [4:0]        cursor_y_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [15:0]       rd_data_reg;
    logic              copy_pend_reg;
    logic [ADDR_W-1:0] copy_dst_reg;
    tcw_out_t          out_reg;
    logic              out_valid_reg;

    logic              on_screen;
    logic [ADDR_W-1:0] at_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic              is_print;
    logic [7:0]        x_step;
    logic [5:0]        y_step;
    logic              wrap;
    logic [7:0]        x_new;
    logic [5:0]        y_new;
    logic              need_scroll;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;

    assign on_screen = ({1'b0, req_reg.column} < 8'(COLUMNS)) &&
                       ({1'b0, req_reg.row} < 6'(ROWS));
    assign at_addr  = ADDR_W'(req_reg.row) * ADDR_W'(COLUMNS) + ADDR_W'(req_reg.column);
    assign cur_addr = ADDR_W'(cursor_y_reg) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_x_reg);

    // Cursor motion of a put request.
    always_comb begin
        is_print = 1'b0;
        y_step   = {1'b0, cursor_y_reg};
        unique case (req_reg.char_code)
            CH_NEWLINE: begin
                x_step = '0;
                y_step = {1'b0, cursor_y_reg} + 6'd1;
            end
            CH_RETURN: begin
                x_step = '0;
            end
            CH_TAB: begin
                x_step = ({1'b0, cursor_x_reg} + 8'(TAB_STEP)) & ~8'(TAB_STEP - 1);
            end
            default: begin
                is_print = 1'b1;
                x_step   = {1'b0, cursor_x_reg} + 8'd1;
            end
        endcase
        wrap        = (x_step >= 8'(COLUMNS));
        x_new       = wrap ? 8'd0 : x_step;
        y_new       = wrap ? y_step + 6'd1 : y_step;
        need_scroll = (y_new >= 6'(ROWS));
    end

    assign stat.req_type    = req_reg.req_type;
    assign stat.need_scroll = need_scroll;
    assign stat.cnt_last    = (cnt_reg == ADDR_W'(CELLS - 1));
    assign stat.out_free    = !out_valid_reg || m_ready;

    // Read port: copy source during scroll, or the addressed cell.
    assign rd_en   = cmd.copy_rd || (cmd.exec && req_reg.req_type == REQ_READ);
    assign rd_addr = cmd.copy_rd ? cnt_reg : at_addr;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = {attr, req_reg.char_code};
        if (copy_pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = copy_dst_reg;
            wr_data = rd_data_reg;
        end else if (cmd.blank_wr) begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
            wr_data = {attr, CH_BLANK};
        end else if (cmd.exec && req_reg.req_type == REQ_PUT && is_print) begin
            wr_en   = 1'b1;
            wr_addr = cur_addr;
        end else if (cmd.exec && req_reg.req_type == REQ_WRITE && on_screen) begin
            wr_en   = 1'b1;
            wr_addr = at_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            screen_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= screen_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        copy_dst_reg <= cnt_reg - ADDR_W'(COLUMNS);
        if (cmd.cnt_load) begin
            unique case (cmd.cnt_sel)
                CNT_COLS:     cnt_reg <= ADDR_W'(COLUMNS);
                CNT_LAST_ROW: cnt_reg <= ADDR_W'(CELLS - COLUMNS);
                default:      cnt_reg <= '0;
            endcase
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + ADDR_W'(1);
        end
        if (cmd.load_out) begin
            out_reg.cursor_col <= cursor_x_reg;
            out_reg.cursor_row <= cursor_y_reg;
            if (req_reg.req_type == REQ_READ && on_screen) begin
                out_reg.cell_char <= rd_data_reg[7:0];
                out_reg.cell_attr <= rd_data_reg[15:8];
            end else begin
                out_reg.cell_char <= '0;
                out_reg.cell_attr <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            copy_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            copy_pend_reg <= cmd.copy_rd;
            if (cmd.exec && req_reg.req_type == REQ_PUT) begin
                cursor_x_reg <= x_new[6:0];
                cursor_y_reg <= need_scroll ? 5'(ROWS - 1) : y_new[4:0];
            end else if (cmd.exec && req_reg.req_type == REQ_CLEAR) begin
                cursor_x_reg <= '0;
                cursor_y_reg <= '0;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

@@ rtl/text_console_writer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console with cursor, scroll, clear and cell access.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (valid/ready) as one packed item: put
// character, clear screen, write at position or read cell. Each request gives
// exactly one result item on the m_ channel carrying the cursor after the
// request and, for a read, the cell's character and attribute bytes.
// Colors are set over the APB port: fg_color at 0x0, bg_color at 0x4.
// Order: a put, write-at or read passes through an execute and a finish state
// before its result is valid, and the next item is accepted back in idle.
// A put that scrolls and a clear both walk the screen store one cell a cycle,
// a scroll copy through its single read port and single write port and a
// clear through the write port alone.
// One request is worked on at a time. The result sits in an output register,
// so a new request is taken while it waits; if the receiver stalls, the next
// result holds in the sequencer until the register is free.
// Reset homes the cursor and sets the colors to 7 on 0; the screen store is
// not cleared and must be cleared by a request before it is read.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
    parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
    parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tcw_pkg::tcw_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tcw_pkg::tcw_out_t      m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import tcw_pkg::*;

    logic [3:0] fg_color_reg;
    logic [3:0] bg_color_reg;
    tcw_cmd_t   cmd;
    tcw_stat_t  stat;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {28'd0, bg_color_reg} : {28'd0, fg_color_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_color_reg <= 4'd7;
            bg_color_reg <= 4'd0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                bg_color_reg <= pwdata[3:0];
            end else begin
                fg_color_reg <= pwdata[3:0];
            end
        end
    end

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .attr    ({bg_color_reg, fg_color_reg}),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Only one request is in flight: after an item is taken the input closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a request is in progress");

    // A result is never loaded over one that the receiver has not taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && m_valid) |-> m_ready)
        else $error("result overwritten before it was taken");

    // The reported cursor always lies on the screen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.cursor_col} < 8'(COLUMNS) &&
                     {1'b0, m_data.cursor_row} < 6'(ROWS)))
        else $error("cursor off screen");

    // Screen walks never run while the input is open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.copy_rd || cmd.blank_wr) |-> !s_ready)
        else $error("screen walk while idle");

endmodule
`default_nettype wire

@@ sim/text_console_writer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top_tb
// Self-checking bench for the character-cell text console.
// ----------------------------------------------------------------------------
// A short scripted sequence covers every request type, the control
// characters, line wrap, scrolling and out-of-range positions. It is followed
// by random request streams under several color settings. A behavioral copy
// of the console predicts each result the script does not fix, and the result
// channel is compared field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;
    import tcw_pkg::*;

    localparam int COLS  = TCW_COLUMNS;
    localparam int ROWS  = TCW_ROWS;
    localparam int CELLS = COLS * ROWS;

    localparam logic [2:0] ADDR_FG_COLOR = 3'd0;
    localparam logic [2:0] ADDR_BG_COLOR = 3'd4;
    localparam logic [7:0] ATTR_RESET    = 8'h07;

    localparam int SCRIPT_LEN      = 28;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int DRAIN_CYCLES    = 64;
    localparam int STALL_LIMIT     = 20000;

    localparam logic [3:0] PHASE_FG [4] = '{4'd0, 4'd15, 4'd15, 4'd0};
    localparam logic [3:0] PHASE_BG [4] = '{4'd0, 4'd15, 4'd0, 4'd15};

    localparam tcw_out_t NO_RES = '0;

    typedef struct packed {
        tcw_in_t    req;
        logic [7:0] reps;
        logic       typed;
        tcw_out_t   res;
    } script_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    tcw_in_t     s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    tcw_out_t    m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Behavioral copy of the console.
    logic [15:0] screen_copy [CELLS];
    int          cursor_col_q;
    int          cursor_row_q;
    logic [3:0]  fg_color_q = 4'd7;
    logic [3:0]  bg_color_q = 4'd0;

    tcw_out_t    pending_results [$];
    script_row_t script [SCRIPT_LEN];
    int          mismatch_count = 0;
    int          slow_budget    = 150;
    int          feed_quiet     = 0;
    int          sink_quiet     = 0;

    text_console_writer_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Mostly random waits, with occasional runs of items that do not wait at all.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet_left = $urandom_range(16, 64);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic console_step(input tcw_in_t req, output tcw_out_t res);
        logic [7:0] attr;
        logic [15:0] cell_word;
        bit on_screen;
        attr = {bg_color_q, fg_color_q};
        on_screen = (req.column < COLS) && (req.row < ROWS);
        res = '0;
        case (req.req_type)
            REQ_PUT: begin
                case (req.char_code)
                    CH_NEWLINE: begin
                        cursor_col_q = 0;
                        cursor_row_q++;
                    end
                    CH_RETURN: cursor_col_q = 0;
                    CH_TAB: cursor_col_q = (cursor_col_q + TAB_STEP) & ~(TAB_STEP - 1);
                    default: begin
                        screen_copy[cursor_row_q * COLS + cursor_col_q] = {attr, req.char_code};
                        cursor_col_q++;
                    end
                endcase
                if (cursor_col_q >= COLS) begin
                    cursor_col_q = 0;
                    cursor_row_q++;
                end
                if (cursor_row_q >= ROWS) begin
                    for (int i = 0; i < CELLS - COLS; i++) screen_copy[i] = screen_copy[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++) screen_copy[i] = {attr, CH_BLANK};
                    cursor_row_q = ROWS - 1;
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen_copy[i] = {attr, CH_BLANK};
                cursor_col_q = 0;
                cursor_row_q = 0;
            end
            REQ_WRITE: begin
                if (on_screen) screen_copy[req.row * COLS + req.column] = {attr, req.char_code};
            end
            default: begin
                if (on_screen) begin
                    cell_word = screen_copy[req.row * COLS + req.column];
                    res.cell_char = cell_word[7:0];
                    res.cell_attr = cell_word[15:8];
                end
            end
        endcase
        res.cursor_col = 7'(cursor_col_q);
        res.cursor_row = 5'(cursor_row_q);
    endtask

    // Called at a rising edge; returns at the edge where the item is accepted.
    task automatic send_request(input tcw_in_t req, input logic typed, input tcw_out_t typed_res);
        int gap;
        tcw_out_t predicted;
        gap = draw_wait(feed_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        console_step(req, predicted);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic next_request(output tcw_in_t req);
        int pick;
        int nc;
        int nr;
        bit slow;
        pick = $urandom_range(0, 999);
        req.char_code = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 6) == 0) begin
            req.column = 7'($urandom_range(0, 127));
            req.row    = 5'($urandom_range(0, 31));
        end else begin
            req.column = 7'($urandom_range(0, COLS - 1));
            req.row    = 5'($urandom_range(0, ROWS - 1));
        end
        if (pick < 550) begin
            req.req_type = REQ_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 15) req.char_code = CH_NEWLINE;
            else if (pick < 20) req.char_code = CH_RETURN;
            else if (pick < 28) req.char_code = CH_TAB;
        end else if (pick < 554) begin
            req.req_type = REQ_CLEAR;
        end else if (pick < 754) begin
            req.req_type = REQ_WRITE;
        end else begin
            req.req_type = REQ_READ;
        end

        // Clears and scrolling puts walk the whole screen, so their number is bounded.
        slow = (req.req_type == REQ_CLEAR);
        if (req.req_type == REQ_PUT) begin
            nc = cursor_col_q;
            nr = cursor_row_q;
            case (req.char_code)
                CH_NEWLINE: begin
                    nc = 0;
                    nr++;
                end
                CH_RETURN: nc = 0;
                CH_TAB: nc = (nc + TAB_STEP) & ~(TAB_STEP - 1);
                default: nc++;
            endcase
            if (nc >= COLS) nr++;
            slow = (nr >= ROWS);
        end
        if (slow) begin
            if (slow_budget == 0) req.req_type = REQ_READ;
            else slow_budget--;
        end
    endtask

    // Leaves psel high so that transfers can follow back to back.
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [3:0] val,
                              output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= {28'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rd = prdata;
    endtask

    task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
        logic [31:0] rd;
        apb_access(1'b1, ADDR_FG_COLOR, fg, rd);
        apb_access(1'b1, ADDR_BG_COLOR, bg, rd);
        apb_access(1'b0, ADDR_FG_COLOR, 4'd0, rd);
        check_field("fg_color", 8'(fg), 8'(rd[3:0]));
        apb_access(1'b0, ADDR_BG_COLOR, 4'd0, rd);
        check_field("bg_color", 8'(bg), 8'(rd[3:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        fg_color_q = fg;
        bg_color_q = bg;
    endtask

    initial begin : result_sink
        int stall;
        tcw_out_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_wait(sink_quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item, expected none, got %h", $time, m_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("cursor_col", 8'(want.cursor_col), 8'(m_data.cursor_col));
                check_field("cursor_row", 8'(want.cursor_row), 8'(m_data.cursor_row));
                check_field("cell_char", want.cell_char, m_data.cell_char);
                check_field("cell_attr", want.cell_attr, m_data.cell_attr);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        tcw_in_t req;
        logic [3:0] fg;
        logic [3:0] bg;

        // The screen must be cleared before anything is read from it.
        script[0]  = '{'{REQ_CLEAR, 8'h00, 7'd0, 5'd0}, 8'd1, 1'b1,
                       '{7'd0, 5'd0, 8'h00, 8'h00}};
        script[1]  = '{'{REQ_READ, 8'h00, 7'd0, 5'd0}, 8'd1, 1'b1,
                       '{7'd0, 5'd0, CH_BLANK, ATTR_RESET}};
        script[2]  = '{'{REQ_PUT, 8'h41, 7'd0, 5'd0}, 8'd1, 1'b1, '{7'd1, 5'd0, 8'h00, 8'h00}};
        script[3]  = '{'{REQ_READ, 8'h00, 7'd0, 5'd0}, 8'd1, 1'b1,
                       '{7'd1, 5'd0, 8'h41, ATTR_RESET}};
        script[4]  = '{'{REQ_PUT, CH_TAB, 7'd0, 5'd0}, 8'd1, 1'b1, '{7'd8, 5'd0, 8'h00, 8'h00}};
        script[5]  = '{'{REQ_PUT, CH_RETURN, 7'd0, 5'd0}, 8'd1, 1'b1,
                       '{7'd0, 5'd0, 8'h00, 8'h00}};
        script[6]  = '{'{REQ_PUT, CH_NEWLINE, 7'd0, 5'd0}, 8'd1, 1'b1,
                       '{7'd0, 5'd1, 8'h00, 8'h00}};
        script[7]  = '{'{REQ_WRITE, 8'hFF, 7'd79, 5'd24}, 8'd1, 1'b1,
                       '{7'd0, 5'd1, 8'h00, 8'h00}};
        script[8]  = '{'{REQ_READ, 8'h00, 7'd79, 5'd24}, 8'd1, 1'b1,
                       '{7'd0, 5'd1, 8'hFF, ATTR_RESET}};
        script[9]  = '{'{REQ_WRITE, 8'hAA, 7'd80, 5'd0}, 8'd1, 1'b1,
                       '{7'd0, 5'd1, 8'h00, 8'h00}};
        script[10] = '{'{REQ_READ, 8'h00, 7'd80, 5'd0}, 8'd1, 1'b1,
                       '{7'd0, 5'd1, 8'h00, 8'h00}};
        script[11] = '{'{REQ_WRITE, 8'hAA, 7'd0, 5'd25}, 8'd1, 1'b1,
                       '{7'd0, 5'd1, 8'h00, 8'h00}};
        script[12] = '{'{REQ_READ, 8'h00, 7'd0, 5'd25}, 8'd1, 1'b1,
                       '{7'd0, 5'd1, 8'h00, 8'h00}};
        script[13] = '{'{REQ_WRITE, 8'h55, 7'd127, 5'd31}, 8'd1, 1'b1,
                       '{7'd0, 5'd1, 8'h00, 8'h00}};
        script[14] = '{'{REQ_READ, 8'h00, 7'd127, 5'd31}, 8'd1, 1'b1,
                       '{7'd0, 5'd1, 8'h00, 8'h00}};
        script[15] = '{'{REQ_PUT, 8'h00, 7'd0, 5'd0}, 8'd1, 1'b1, '{7'd1, 5'd1, 8'h00, 8'h00}};
        script[16] = '{'{REQ_PUT, 8'hFF, 7'd0, 5'd0}, 8'd1, 1'b1, '{7'd2, 5'd1, 8'h00, 8'h00}};
        script[17] = '{'{REQ_WRITE, 8'h00, 7'd0, 5'd0}, 8'd1, 1'b1,
                       '{7'd2, 5'd1, 8'h00, 8'h00}};
        script[18] = '{'{REQ_READ, 8'h00, 7'd0, 5'd0}, 8'd1, 1'b1,
                       '{7'd2, 5'd1, 8'h00, ATTR_RESET}};
        // Walk down to the last row, then scroll with a newline.
        script[19] = '{'{REQ_PUT, CH_NEWLINE, 7'd0, 5'd0}, 8'd23, 1'b0, NO_RES};
        script[20] = '{'{REQ_PUT, CH_NEWLINE, 7'd0, 5'd0}, 8'd1, 1'b1,
                       '{7'd0, 5'd24, 8'h00, 8'h00}};
        script[21] = '{'{REQ_READ, 8'h00, 7'd79, 5'd23}, 8'd1, 1'b0, NO_RES};
        // A tab from the last tab stop wraps the line and scrolls.
        script[22] = '{'{REQ_PUT, CH_TAB, 7'd0, 5'd0}, 8'd9, 1'b0, NO_RES};
        script[23] = '{'{REQ_PUT, CH_TAB, 7'd0, 5'd0}, 8'd1, 1'b1,
                       '{7'd0, 5'd24, 8'h00, 8'h00}};
        // Filling the line end with characters wraps and scrolls as well.
        script[24] = '{'{REQ_PUT, CH_TAB, 7'd0, 5'd0}, 8'd9, 1'b0, NO_RES};
        script[25] = '{'{REQ_PUT, 8'h79, 7'd0, 5'd0}, 8'd8, 1'b0, NO_RES};
        script[26] = '{'{REQ_READ, 8'h00, 7'd79, 5'd23}, 8'd1, 1'b0, NO_RES};
        script[27] = '{'{REQ_READ, 8'h00, 7'd0, 5'd24}, 8'd1, 1'b1,
                       '{7'd0, 5'd24, CH_BLANK, ATTR_RESET}};

        cursor_col_q = 0;
        cursor_row_q = 0;
        for (int i = 0; i < CELLS; i++) screen_copy[i] = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < SCRIPT_LEN; r++) begin
            for (int k = 0; k < script[r].reps; k++)
                send_request(script[r].req, script[r].typed, script[r].res);
        end

        for (int p = 0; p < PHASES; p++) begin
            s_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge aclk);
            fg = (p < 4) ? PHASE_FG[p] : 4'($urandom);
            bg = (p < 4) ? PHASE_BG[p] : 4'($urandom);
            set_colors(fg, bg);
            @(posedge aclk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                next_request(req);
                send_request(req, 1'b0, NO_RES);
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
